[hdl/xstb_pkg.sv]
`default_nettype none
package xstb_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int STACK_DW = $clog2(STACK_DEPTH + 1);
  localparam int RECORD_BYTES = 16;
  localparam logic [31:0] ATTR_MARK = 32'h8000_0000;
  localparam int MAX_RESULTS = 4;
  localparam int RES_CW = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [15:0] ARENA_START_RST = 16'd16;
  localparam logic [23:0] ARENA_RECORDS_RST = 24'd65536;

  typedef enum logic [3:0] {
    PH_CONTENT, PH_TEXT, PH_LT, PH_CLOSE, PH_SKIP, PH_NAME, PH_ATTRS,
    PH_ANAME, PH_AEQ, PH_AVALWS, PH_AVAL, PH_ABREAK, PH_SLASH
  } phase_t;

  typedef enum logic [2:0] {
    K_ELEM, K_ATTR, K_TEXT, K_FIRST_CHILD, K_NEXT_SIBLING, K_NEXT_ATTR, K_TERM, K_DONE
  } kind_t;

  typedef enum logic [1:0] {REC_NONE, REC_TEXT, REC_ELEM, REC_ATTR} rec_t;

  typedef enum logic {CFG_ARENA_START, CFG_ARENA_RECORDS} cfg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] node;
    logic [31:0] a;
    logic [31:0] b;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        link_en;
    logic [31:0] child;
    logic        push_en;
    logic [31:0] push_elem;
    logic        pop_en;
    logic        clr;
  } stk_cmd_t;

  typedef struct packed {
    logic [STACK_DW-1:0] depth;
    logic [31:0]         elem;
    logic [31:0]         last;
    logic                busy;
  } stk_stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_nstart(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == ":";
  endfunction

  function automatic logic is_nchar(input logic [7:0] c);
    return is_nstart(c) || (c >= "0" && c <= "9") || c == "-" || c == ".";
  endfunction

endpackage
`default_nettype wire

[hdl/xstb_stack.sv]
`default_nettype none
module xstb_stack (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire xstb_pkg::stk_cmd_t   cmd,
  output xstb_pkg::stk_stat_t       stat
);

  logic [63:0] mem [xstb_pkg::STACK_DEPTH];
  logic [63:0] rd_q;
  logic [xstb_pkg::STACK_DW-1:0] depth_r;
  logic [31:0] elem_r;
  logic [31:0] last_r;
  logic        ld_r;

  logic [31:0] last_mod;
  logic        full;
  logic        wr_en;
  logic        rd_en;
  logic [xstb_pkg::STACK_DW-1:0] dm1;
  logic [xstb_pkg::STACK_DW-1:0] dm2;

  always_comb begin
    last_mod = cmd.link_en ? cmd.child : last_r;
    full     = depth_r == xstb_pkg::STACK_DW'(xstb_pkg::STACK_DEPTH);
    dm1      = depth_r - xstb_pkg::STACK_DW'(1);
    dm2      = depth_r - xstb_pkg::STACK_DW'(2);
    wr_en    = cmd.push_en && !full && depth_r != '0 && !cmd.clr;
    rd_en    = cmd.pop_en && depth_r >= xstb_pkg::STACK_DW'(2) && !cmd.clr;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[dm1[xstb_pkg::STACK_AW-1:0]] <= {elem_r, last_mod};
    end
    if (rd_en) begin
      rd_q <= mem[dm2[xstb_pkg::STACK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      ld_r    <= 1'b0;
    end else if (cmd.clr) begin
      depth_r <= '0;
      ld_r    <= 1'b0;
    end else begin
      ld_r <= rd_en;
      if (cmd.push_en && !full) begin
        depth_r <= depth_r + xstb_pkg::STACK_DW'(1);
      end else if (cmd.pop_en && depth_r != '0) begin
        depth_r <= dm1;
      end
    end
  end

  // top of stack lives in flops; entries below it sit in the memory
  always_ff @(posedge clk) begin
    if (ld_r) begin
      {elem_r, last_r} <= rd_q;
    end else if (cmd.push_en && !full) begin
      elem_r <= cmd.push_elem;
      last_r <= '0;
    end else if (cmd.link_en) begin
      last_r <= last_mod;
    end
  end

  assign stat = '{depth: depth_r, elem: elem_r, last: last_r, busy: ld_r};

endmodule
`default_nettype wire

[hdl/xstb_rfifo.sv]
`default_nettype none
module xstb_rfifo (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire xstb_pkg::result_t [xstb_pkg::MAX_RESULTS-1:0]  wr_data,
  input  wire logic [xstb_pkg::RES_CW-1:0]                    wr_cnt,
  output logic                                                room,
  output logic                                                out_valid,
  input  wire logic                                           out_ready,
  output xstb_pkg::result_t                                   out_data
);

  xstb_pkg::result_t q [xstb_pkg::FIFO_DEPTH];
  logic [xstb_pkg::FIFO_AW-1:0] wptr_r;
  logic [xstb_pkg::FIFO_AW-1:0] rptr_r;
  logic [xstb_pkg::FIFO_CW-1:0] cnt_r;
  logic                         pop;

  always_comb begin
    out_valid = cnt_r != '0;
    pop       = out_valid && out_ready;
    out_data  = q[rptr_r];
    room      = cnt_r <= xstb_pkg::FIFO_CW'(xstb_pkg::FIFO_DEPTH - xstb_pkg::MAX_RESULTS);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < xstb_pkg::MAX_RESULTS; k++) begin
      if (xstb_pkg::RES_CW'(k) < wr_cnt) begin
        q[wptr_r + xstb_pkg::FIFO_AW'(k)] <= wr_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + xstb_pkg::FIFO_AW'(wr_cnt);
      rptr_r <= rptr_r + xstb_pkg::FIFO_AW'(pop);
      cnt_r  <= cnt_r + xstb_pkg::FIFO_CW'(wr_cnt) - xstb_pkg::FIFO_CW'(pop);
    end
  end

endmodule
`default_nettype wire

[hdl/xstb_parse.sv]
`default_nettype none
module xstb_parse (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic                                           step_en,
  input  wire logic [7:0]                                     data_byte,
  input  wire logic                                           end_of_input,
  input  wire logic [15:0]                                    arena_start,
  input  wire logic [23:0]                                    arena_records,
  input  wire xstb_pkg::stk_stat_t                            stk,
  output xstb_pkg::stk_cmd_t                                  stk_cmd,
  output xstb_pkg::result_t [xstb_pkg::MAX_RESULTS-1:0]       res,
  output logic [xstb_pkg::RES_CW-1:0]                         res_cnt
);

  xstb_pkg::phase_t ph_r;
  logic [31:0] pos_r;
  logic [31:0] next_off_r;
  logic [23:0] used_r;
  logic [31:0] otag_r;
  logic [31:0] prev_attr_r;
  logic [31:0] ts_r;
  logic [31:0] vs_r;
  logic [7:0]  qc_r;
  logic [31:0] root_r;
  logic        root_found_r;
  logic        ovf_r;

  xstb_pkg::phase_t ph_nxt;
  logic [31:0] ts_nxt;
  logic [31:0] vs_nxt;
  logic [7:0]  qc_nxt;
  logic        term_w;
  xstb_pkg::rec_t rec_w;
  logic        push_w;
  logic        pop_w;
  logic        ok;

  xstb_pkg::rec_t rec_k;
  logic        is_eoi;
  logic        rec_do;
  logic        link_v;
  logic [31:0] off;
  logic        root_set;
  logic [31:0] root_nxt;
  logic        found_nxt;
  logic        ovf_nxt;

  assign ok  = used_r < arena_records;
  assign off = next_off_r;

  // next state: walk the phases for one byte
  always_comb begin
    xstb_pkg::phase_t ph;
    logic fin;
    logic [xstb_pkg::STACK_DW-1:0] d;
    logic brk;
    ph = ph_r;
    fin = 1'b0;
    d = stk.depth;
    ts_nxt = ts_r;
    vs_nxt = vs_r;
    qc_nxt = qc_r;
    term_w = 1'b0;
    rec_w = xstb_pkg::REC_NONE;
    push_w = 1'b0;
    pop_w = 1'b0;
    for (int i = 0; i < 5; i++) begin
      brk = 1'b0;
      if (!fin) begin
        case (ph)
          xstb_pkg::PH_CONTENT: begin
            fin = 1'b1;
            if (xstb_pkg::is_ws(data_byte)) begin
            end else if (data_byte == "<") begin
              ph = xstb_pkg::PH_LT;
            end else if (d != '0) begin
              ts_nxt = pos_r;
              ph = xstb_pkg::PH_TEXT;
            end
          end
          xstb_pkg::PH_TEXT: begin
            fin = 1'b1;
            if (data_byte == "<") begin
              rec_w = xstb_pkg::REC_TEXT;
              term_w = 1'b1;
              ph = xstb_pkg::PH_LT;
            end
          end
          xstb_pkg::PH_LT: begin
            fin = 1'b1;
            if (data_byte == "/") begin
              ph = xstb_pkg::PH_CLOSE;
            end else if (data_byte == "?" || data_byte == "!") begin
              ph = xstb_pkg::PH_SKIP;
            end else if (xstb_pkg::is_nchar(data_byte)) begin
              ts_nxt = pos_r;
              ph = xstb_pkg::PH_NAME;
            end else begin
              ph = xstb_pkg::PH_CONTENT;
              fin = 1'b0;
            end
          end
          xstb_pkg::PH_CLOSE: begin
            fin = 1'b1;
            if (data_byte == ">") begin
              pop_w = d != '0;
              ph = xstb_pkg::PH_CONTENT;
            end
          end
          xstb_pkg::PH_SKIP: begin
            fin = 1'b1;
            if (data_byte == ">") begin
              ph = xstb_pkg::PH_CONTENT;
            end
          end
          xstb_pkg::PH_NAME: begin
            if (xstb_pkg::is_nchar(data_byte)) begin
              fin = 1'b1;
            end else begin
              rec_w = xstb_pkg::REC_ELEM;
              term_w = 1'b1;
              ph = ok ? xstb_pkg::PH_ATTRS : xstb_pkg::PH_CONTENT;
            end
          end
          xstb_pkg::PH_ATTRS: begin
            if (xstb_pkg::is_ws(data_byte)) begin
              fin = 1'b1;
            end else if (xstb_pkg::is_nstart(data_byte)) begin
              ts_nxt = pos_r;
              ph = xstb_pkg::PH_ANAME;
              fin = 1'b1;
            end else begin
              brk = 1'b1;
            end
          end
          xstb_pkg::PH_ANAME: begin
            if (xstb_pkg::is_nchar(data_byte)) begin
              fin = 1'b1;
            end else begin
              term_w = 1'b1;
              ph = xstb_pkg::PH_AEQ;
            end
          end
          xstb_pkg::PH_AEQ: begin
            if (xstb_pkg::is_ws(data_byte)) begin
              fin = 1'b1;
            end else if (data_byte == "=") begin
              ph = xstb_pkg::PH_AVALWS;
              fin = 1'b1;
            end else begin
              brk = 1'b1;
            end
          end
          xstb_pkg::PH_AVALWS: begin
            if (xstb_pkg::is_ws(data_byte)) begin
              fin = 1'b1;
            end else if (data_byte == 8'h22 || data_byte == 8'h27) begin
              qc_nxt = data_byte;
              vs_nxt = pos_r + 32'd1;
              ph = xstb_pkg::PH_AVAL;
              fin = 1'b1;
            end else begin
              brk = 1'b1;
            end
          end
          xstb_pkg::PH_AVAL: begin
            fin = 1'b1;
            if (data_byte == qc_nxt) begin
              rec_w = xstb_pkg::REC_ATTR;
              term_w = 1'b1;
              ph = ok ? xstb_pkg::PH_ATTRS : xstb_pkg::PH_ABREAK;
            end
          end
          xstb_pkg::PH_ABREAK: begin
            brk = 1'b1;
          end
          xstb_pkg::PH_SLASH: begin
            ph = xstb_pkg::PH_CONTENT;
            fin = data_byte == ">";
          end
          default: begin
            ph = xstb_pkg::PH_CONTENT;
          end
        endcase
        if (brk) begin
          if (data_byte == "/") begin
            ph = xstb_pkg::PH_SLASH;
            fin = 1'b1;
          end else begin
            push_w = 1'b1;
            if (d != xstb_pkg::STACK_DW'(xstb_pkg::STACK_DEPTH)) begin
              d = d + xstb_pkg::STACK_DW'(1);
            end
            ph = xstb_pkg::PH_CONTENT;
            fin = data_byte == ">";
          end
        end
      end
    end
    ph_nxt = ph;
  end

  // outputs: build results and stack commands
  always_comb begin
    xstb_pkg::result_t cand [xstb_pkg::MAX_RESULTS];
    logic [xstb_pkg::MAX_RESULTS-1:0] v;
    logic [xstb_pkg::RES_CW-1:0] n;
    logic [xstb_pkg::RES_CW-1:0] feed_n;
    logic feed_link;
    logic after_push;
    logic t_nz;
    logic [31:0] t_elem;
    logic [31:0] t_last;
    logic [31:0] ts_u;
    logic [31:0] vs_u;
    logic [31:0] endp;
    logic err;
    xstb_pkg::rec_t eoi_k;

    feed_link = rec_w == xstb_pkg::REC_ATTR || stk.depth != '0;
    feed_n = xstb_pkg::RES_CW'(term_w);
    if (rec_w != xstb_pkg::REC_NONE && ok) begin
      feed_n = feed_n + xstb_pkg::RES_CW'(1) + xstb_pkg::RES_CW'(feed_link);
    end
    eoi_k = xstb_pkg::REC_NONE;
    if (end_of_input) begin
      if (ph_nxt == xstb_pkg::PH_NAME) begin
        eoi_k = xstb_pkg::REC_ELEM;
      end else if (ph_nxt == xstb_pkg::PH_TEXT && feed_n <= xstb_pkg::RES_CW'(1)) begin
        eoi_k = xstb_pkg::REC_TEXT;
      end else if (ph_nxt == xstb_pkg::PH_AVAL) begin
        eoi_k = xstb_pkg::REC_ATTR;
      end
    end
    is_eoi = rec_w == xstb_pkg::REC_NONE;
    rec_k  = is_eoi ? eoi_k : rec_w;
    rec_do = rec_k != xstb_pkg::REC_NONE && ok;

    after_push = is_eoi && push_w &&
                 stk.depth != xstb_pkg::STACK_DW'(xstb_pkg::STACK_DEPTH);
    t_nz   = after_push || stk.depth != '0;
    t_elem = after_push ? otag_r : stk.elem;
    t_last = after_push ? 32'd0 : stk.last;
    ts_u   = is_eoi ? ts_nxt : ts_r;
    vs_u   = is_eoi ? vs_nxt : vs_r;
    endp   = is_eoi ? pos_r + 32'd1 : pos_r;

    cand[0] = '{kind: xstb_pkg::K_TERM, node: 32'd0, a: pos_r, b: 32'd0, last: 1'b0};
    cand[1] = '{kind: xstb_pkg::K_TEXT, node: off, a: ts_u, b: endp - ts_u, last: 1'b0};
    cand[2] = '{kind: xstb_pkg::K_FIRST_CHILD, node: t_elem, a: off, b: 32'd0, last: 1'b0};
    link_v = t_nz;
    case (rec_k)
      xstb_pkg::REC_ELEM: begin
        cand[1].kind = xstb_pkg::K_ELEM;
        cand[1].b = t_nz ? t_elem : 32'd0;
      end
      xstb_pkg::REC_ATTR: begin
        cand[1].kind = xstb_pkg::K_ATTR;
        cand[1].a = ts_u | xstb_pkg::ATTR_MARK;
        cand[1].b = vs_u;
        link_v = 1'b1;
      end
      default: begin
      end
    endcase
    if (rec_k == xstb_pkg::REC_ATTR) begin
      if (prev_attr_r == '0) begin
        cand[2].node = otag_r;
      end else begin
        cand[2].kind = xstb_pkg::K_NEXT_ATTR;
        cand[2].node = prev_attr_r;
      end
    end else if (t_last != '0) begin
      cand[2].kind = xstb_pkg::K_NEXT_SIBLING;
      cand[2].node = t_last;
    end

    root_set  = rec_do && rec_k == xstb_pkg::REC_ELEM && !t_nz && !root_found_r;
    root_nxt  = root_set ? off : root_r;
    found_nxt = root_found_r || root_set;
    ovf_nxt   = ovf_r || (rec_k != xstb_pkg::REC_NONE && !ok);
    err       = !found_nxt || root_nxt == '0 || ovf_nxt;
    cand[3] = '{kind: xstb_pkg::K_DONE, node: 32'd0, a: err ? 32'd0 : root_nxt,
                b: {31'd0, err}, last: 1'b0};

    v = {end_of_input, rec_do && link_v, rec_do, term_w};
    res = '0;
    n = '0;
    for (int k = 0; k < xstb_pkg::MAX_RESULTS; k++) begin
      if (v[k]) begin
        res[n[xstb_pkg::RES_CW-2:0]] = cand[k];
        n = n + xstb_pkg::RES_CW'(1);
      end
    end
    if (n != '0) begin
      res[n[xstb_pkg::RES_CW-2:0] - 1'b1].last = 1'b1;
    end
    res_cnt = step_en ? n : '0;

    stk_cmd.link_en   = step_en && rec_do && !is_eoi && rec_k != xstb_pkg::REC_ATTR &&
                        stk.depth != '0;
    stk_cmd.child     = off;
    stk_cmd.push_en   = step_en && push_w;
    stk_cmd.push_elem = (rec_do && rec_k == xstb_pkg::REC_ELEM) ? off : otag_r;
    stk_cmd.pop_en    = step_en && pop_w;
    stk_cmd.clr       = step_en && end_of_input;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r         <= xstb_pkg::PH_CONTENT;
      pos_r        <= '0;
      next_off_r   <= {16'd0, xstb_pkg::ARENA_START_RST};
      used_r       <= '0;
      otag_r       <= '0;
      prev_attr_r  <= '0;
      ts_r         <= '0;
      vs_r         <= '0;
      qc_r         <= '0;
      root_r       <= '0;
      root_found_r <= 1'b0;
      ovf_r        <= 1'b0;
    end else if (step_en) begin
      if (end_of_input) begin
        ph_r         <= xstb_pkg::PH_CONTENT;
        pos_r        <= '0;
        next_off_r   <= {16'd0, arena_start};
        used_r       <= '0;
        otag_r       <= '0;
        prev_attr_r  <= '0;
        ts_r         <= '0;
        vs_r         <= '0;
        qc_r         <= '0;
        root_r       <= '0;
        root_found_r <= 1'b0;
        ovf_r        <= 1'b0;
      end else begin
        ph_r         <= ph_nxt;
        pos_r        <= pos_r + 32'd1;
        ts_r         <= ts_nxt;
        vs_r         <= vs_nxt;
        qc_r         <= qc_nxt;
        root_r       <= root_nxt;
        root_found_r <= found_nxt;
        ovf_r        <= ovf_nxt;
        if (rec_do) begin
          next_off_r <= next_off_r + 32'(xstb_pkg::RECORD_BYTES);
          used_r     <= used_r + 24'd1;
          if (rec_k == xstb_pkg::REC_ELEM) begin
            otag_r      <= off;
            prev_attr_r <= '0;
          end else if (rec_k == xstb_pkg::REC_ATTR) begin
            prev_attr_r <= off;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[hdl/xml_stream_tree_builder.sv]
// channel  direction  transfer when           payload
// in       input      in_valid & in_ready     in_data_byte, in_end_of_input
// out      output     out_valid & out_ready   out_kind, out_node_offset, out_value_a/b,
//                                             out_last_result
// cfg      input      cfg_we                  cfg_index, cfg_wdata
//
// A byte is parsed in the cycle it is taken; its results (up to four) go into an
// eight-entry result queue and leave it one per cycle while out_ready is high.
// A byte is taken while the queue has four free entries and the stack is not
// reloading, so a stream runs at one byte per cycle while the output keeps up;
// a close tag that uncovers an older stack entry stalls input for the stack
// memory read. Reset is synchronous and needs no clearing pass.
`default_nettype none
module xml_stream_tree_builder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_input,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_node_offset,
  output logic [31:0]      out_value_a,
  output logic [31:0]      out_value_b,
  output logic             out_last_result,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_wdata
);

  logic [15:0] arena_start_r;
  logic [23:0] arena_records_r;
  logic        room;
  logic        accept;
  xstb_pkg::stk_cmd_t  stk_cmd;
  xstb_pkg::stk_stat_t stk_stat;
  xstb_pkg::result_t [xstb_pkg::MAX_RESULTS-1:0] res;
  logic [xstb_pkg::RES_CW-1:0] res_cnt;
  xstb_pkg::result_t out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_start_r   <= xstb_pkg::ARENA_START_RST;
      arena_records_r <= xstb_pkg::ARENA_RECORDS_RST;
    end else if (cfg_we) begin
      if (cfg_index == xstb_pkg::CFG_ARENA_START) begin
        arena_start_r <= cfg_wdata[15:0];
      end else begin
        arena_records_r <= cfg_wdata;
      end
    end
  end

  assign in_ready = room && !stk_stat.busy;
  assign accept   = in_valid && in_ready;

  xstb_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (accept),
    .data_byte     (in_data_byte),
    .end_of_input  (in_end_of_input),
    .arena_start   (arena_start_r),
    .arena_records (arena_records_r),
    .stk           (stk_stat),
    .stk_cmd       (stk_cmd),
    .res           (res),
    .res_cnt       (res_cnt)
  );

  xstb_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .stat  (stk_stat)
  );

  xstb_rfifo u_rfifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_data   (res),
    .wr_cnt    (res_cnt),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_kind        = out_data.kind;
  assign out_node_offset = out_data.node;
  assign out_value_a     = out_data.a;
  assign out_value_b     = out_data.b;
  assign out_last_result = out_data.last;

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == xstb_pkg::K_DONE |-> out_last_result)
    else $error("done result not marked last");

  a_eoi_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_input |=> out_valid)
    else $error("no result after end of document");

  a_busy_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stk_stat.busy) |-> $past(accept))
    else $error("stack reload without a transfer");

endmodule
`default_nettype wire

[sim/xml_stream_tree_builder_test.sv]
`timescale 1ns / 100ps
module xml_stream_tree_builder_test;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_ITEMS = 120;

  class tree_scoreboard;
    int unsigned start_reg, records_reg;
    xstb_pkg::phase_t ph;
    int unsigned pos, depth, next_off, used, open_el, prev_attr, tok, vstart, root;
    logic [7:0] quote;
    bit root_ok, ovf;
    int unsigned stk_el[xstb_pkg::STACK_DEPTH];
    int unsigned stk_lc[xstb_pkg::STACK_DEPTH];
    xstb_pkg::result_t step_q[$];
    xstb_pkg::result_t pending[$];
    int errors, docs, results, bytes_in;

    function new();
      start_reg = 16;
      records_reg = 65536;
      errors = 0;
      docs = 0;
      results = 0;
      bytes_in = 0;
      clear_doc();
    endfunction

    function void clear_doc();
      ph = xstb_pkg::PH_CONTENT;
      pos = 0;
      depth = 0;
      next_off = start_reg;
      used = 0;
      open_el = 0;
      prev_attr = 0;
      tok = 0;
      vstart = 0;
      quote = 0;
      root = 0;
      root_ok = 0;
      ovf = 0;
    endfunction

    function void set_reg(xstb_pkg::cfg_idx_t idx, int unsigned val);
      if (idx == xstb_pkg::CFG_ARENA_START) start_reg = val & 32'hFFFF;
      else records_reg = val & 32'hFF_FFFF;
    endfunction

    function void put(xstb_pkg::kind_t k, int unsigned n, int unsigned a, int unsigned b);
      xstb_pkg::result_t r;
      if (step_q.size() >= xstb_pkg::MAX_RESULTS) return;
      r.kind = k;
      r.node = n;
      r.a = a;
      r.b = b;
      r.last = 1'b0;
      step_q.push_back(r);
    endfunction

    function bit take_record(output int unsigned off);
      if (used >= records_reg) begin
        ovf = 1;
        return 0;
      end
      off = next_off;
      next_off += xstb_pkg::RECORD_BYTES;
      used++;
      return 1;
    endfunction

    function void push_open();
      if (depth < xstb_pkg::STACK_DEPTH) begin
        stk_el[depth] = open_el;
        stk_lc[depth] = 0;
        depth++;
      end
    endfunction

    function void link_child(int unsigned child);
      int unsigned t;
      t = depth - 1;
      if (stk_lc[t] == 0) put(xstb_pkg::K_FIRST_CHILD, stk_el[t], child, 0);
      else put(xstb_pkg::K_NEXT_SIBLING, stk_lc[t], child, 0);
      stk_lc[t] = child;
    endfunction

    function void close_text(int unsigned endp, bit term);
      int unsigned off;
      if (term) put(xstb_pkg::K_TERM, 0, endp, 0);
      if (!take_record(off)) return;
      put(xstb_pkg::K_TEXT, off, tok, endp - tok);
      if (depth > 0) link_child(off);
    endfunction

    function bit close_elem(int unsigned endp, bit term);
      int unsigned off;
      if (term) put(xstb_pkg::K_TERM, 0, endp, 0);
      if (!take_record(off)) return 0;
      put(xstb_pkg::K_ELEM, off, tok, depth > 0 ? stk_el[depth-1] : 0);
      if (depth > 0) link_child(off);
      else if (!root_ok) begin
        root = off;
        root_ok = 1;
      end
      open_el = off;
      prev_attr = 0;
      return 1;
    endfunction

    function bit close_attr(int unsigned endp, bit term);
      int unsigned off;
      if (term) put(xstb_pkg::K_TERM, 0, endp, 0);
      if (!take_record(off)) return 0;
      put(xstb_pkg::K_ATTR, off, tok | xstb_pkg::ATTR_MARK, vstart);
      if (prev_attr == 0) put(xstb_pkg::K_FIRST_CHILD, open_el, off, 0);
      else put(xstb_pkg::K_NEXT_ATTR, prev_attr, off, 0);
      prev_attr = off;
      return 1;
    endfunction

    function bit end_tag(logic [7:0] c);
      if (c == "/") begin
        ph = xstb_pkg::PH_SLASH;
        return 1;
      end
      push_open();
      ph = xstb_pkg::PH_CONTENT;
      return c == ">";
    endfunction

    function void parse(logic [7:0] c, int unsigned p);
      forever begin
        case (ph)
          xstb_pkg::PH_CONTENT: begin
            if (xstb_pkg::is_ws(c)) return;
            if (c == "<") begin
              ph = xstb_pkg::PH_LT;
              return;
            end
            if (depth == 0) return;
            tok = p;
            ph = xstb_pkg::PH_TEXT;
            return;
          end
          xstb_pkg::PH_TEXT: begin
            if (c != "<") return;
            close_text(p, 1);
            ph = xstb_pkg::PH_LT;
            return;
          end
          xstb_pkg::PH_LT: begin
            if (c == "/") begin
              ph = xstb_pkg::PH_CLOSE;
              return;
            end
            if (c == "?" || c == "!") begin
              ph = xstb_pkg::PH_SKIP;
              return;
            end
            if (xstb_pkg::is_nchar(c)) begin
              tok = p;
              ph = xstb_pkg::PH_NAME;
              return;
            end
            ph = xstb_pkg::PH_CONTENT;
          end
          xstb_pkg::PH_CLOSE: begin
            if (c == ">") begin
              if (depth > 0) depth--;
              ph = xstb_pkg::PH_CONTENT;
            end
            return;
          end
          xstb_pkg::PH_SKIP: begin
            if (c == ">") ph = xstb_pkg::PH_CONTENT;
            return;
          end
          xstb_pkg::PH_NAME: begin
            if (xstb_pkg::is_nchar(c)) return;
            ph = close_elem(p, 1) ? xstb_pkg::PH_ATTRS : xstb_pkg::PH_CONTENT;
          end
          xstb_pkg::PH_ATTRS: begin
            if (xstb_pkg::is_ws(c)) return;
            if (xstb_pkg::is_nstart(c)) begin
              tok = p;
              ph = xstb_pkg::PH_ANAME;
              return;
            end
            if (end_tag(c)) return;
          end
          xstb_pkg::PH_ANAME: begin
            if (xstb_pkg::is_nchar(c)) return;
            put(xstb_pkg::K_TERM, 0, p, 0);
            ph = xstb_pkg::PH_AEQ;
          end
          xstb_pkg::PH_AEQ: begin
            if (xstb_pkg::is_ws(c)) return;
            if (c == "=") begin
              ph = xstb_pkg::PH_AVALWS;
              return;
            end
            if (end_tag(c)) return;
          end
          xstb_pkg::PH_AVALWS: begin
            if (xstb_pkg::is_ws(c)) return;
            if (c == "\"" || c == "'") begin
              quote = c;
              vstart = p + 1;
              ph = xstb_pkg::PH_AVAL;
              return;
            end
            if (end_tag(c)) return;
          end
          xstb_pkg::PH_AVAL: begin
            if (c != quote) return;
            ph = close_attr(p, 1) ? xstb_pkg::PH_ATTRS : xstb_pkg::PH_ABREAK;
            return;
          end
          xstb_pkg::PH_ABREAK: begin
            if (end_tag(c)) return;
          end
          xstb_pkg::PH_SLASH: begin
            ph = xstb_pkg::PH_CONTENT;
            if (c == ">") return;
          end
          default: ph = xstb_pkg::PH_CONTENT;
        endcase
      end
    endfunction

    function void note_byte(logic [7:0] c, logic eoi);
      bit err;
      bit dummy;
      step_q.delete();
      bytes_in++;
      parse(c, pos);
      pos++;
      if (eoi) begin
        if (ph == xstb_pkg::PH_NAME) dummy = close_elem(0, 0);
        else if (ph == xstb_pkg::PH_TEXT && step_q.size() + 3 <= xstb_pkg::MAX_RESULTS)
          close_text(pos, 0);
        else if (ph == xstb_pkg::PH_AVAL) dummy = close_attr(0, 0);
        err = !root_ok || root == 0 || ovf;
        put(xstb_pkg::K_DONE, 0, err ? 0 : root, err ? 1 : 0);
        clear_doc();
        docs++;
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
      foreach (step_q[i]) pending.push_back(step_q[i]);
    endfunction

    function void check_result(xstb_pkg::result_t got);
      xstb_pkg::result_t want;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind %0d node %h a %h b %h", $time,
                 got.kind, got.node, got.a, got.b);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind) begin
        $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.node != want.node) begin
        $display("%0t: node_offset exp %h got %h", $time, want.node, got.node);
        errors++;
      end
      if (got.a != want.a) begin
        $display("%0t: value_a exp %h got %h", $time, want.a, got.a);
        errors++;
      end
      if (got.b != want.b) begin
        $display("%0t: value_b exp %h got %h", $time, want.b, got.b);
        errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: last_result exp %0d got %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [31:0] out_node_offset;
  logic [31:0] out_value_a;
  logic [31:0] out_value_b;
  logic        out_last_result;
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_wdata;

  tree_scoreboard sb;
  logic [7:0] doc[$];
  int cycles;
  bit calm;
  int hold_asks;
  int hold_seen;

  xml_stream_tree_builder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_end_of_input(in_end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_node_offset(out_node_offset),
    .out_value_a(out_value_a), .out_value_b(out_value_b),
    .out_last_result(out_last_result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    xstb_pkg::result_t got;
    stall_left = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (calm) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else begin
        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
        out_ready = 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.kind = xstb_pkg::kind_t'(out_kind);
        got.node = out_node_offset;
        got.a = out_value_a;
        got.b = out_value_b;
        got.last = out_last_result;
        sb.check_result(got);
      end
    end
  end

  task automatic send_byte(logic [7:0] c, logic eoi);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = c;
    in_end_of_input = eoi;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(c, eoi);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_doc();
    foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1);
    doc.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
    send_doc();
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic cfg_write(xstb_pkg::cfg_idx_t idx, int unsigned val);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[23:0];
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
  endfunction

  function automatic void add_name();
    string first;
    string rest;
    first = "abqXYZ_:";
    rest = "az09-._Q";
    doc.push_back(first[$urandom_range(0, 7)]);
    repeat ($urandom_range(0, 3)) doc.push_back(rest[$urandom_range(0, 7)]);
  endfunction

  function automatic void add_elem(int lvl);
    logic [7:0] q;
    logic [7:0] c;
    doc.push_back("<");
    add_name();
    repeat ($urandom_range(0, 3)) begin
      add_str($urandom_range(0, 3) == 0 ? "\n" : " ");
      add_name();
      add_str($urandom_range(0, 3) == 0 ? " = " : "=");
      q = $urandom_range(0, 1) ? "\"" : "'";
      doc.push_back(q);
      repeat ($urandom_range(0, 4)) begin
        c = $urandom_range(0, 255);
        if (c == q) c = "v";
        doc.push_back(c);
      end
      doc.push_back(q);
    end
    if (lvl >= 3 || $urandom_range(0, 2) == 0) begin
      add_str($urandom_range(0, 1) ? "/>" : " />");
      return;
    end
    doc.push_back(">");
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0, 1: add_elem(lvl + 1);
        2: begin
          if ($urandom_range(0, 1)) doc.push_back(" ");
          repeat ($urandom_range(1, 5)) doc.push_back($urandom_range(0, 1) ? " " :
                                                       8'($urandom_range(97, 122)));
        end
        3: add_str($urandom_range(0, 1) ? "<!-- n -->" : "<?pi x?>");
        default: add_str("\n\t");
      endcase
    end
    add_str("</");
    add_name();
    doc.push_back(">");
  endfunction

  initial begin
    int sent;
    int docs_since_cfg;
    bit held;
    bit paused;
    sb = new();
    cycles = 0;
    calm = 1'b0;
    hold_asks = 0;
    hold_seen = 0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_end_of_input = 1'b0;
    cfg_we = 1'b0;
    cfg_index = xstb_pkg::CFG_ARENA_START;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_text("<?x?><!--c--><r a='1' b=\"2\">t<c/> u</r>");
    send_text("</x>top<r>");
    send_text("<r><a");
    send_text("<r>txt");
    send_text("<r a='v");
    send_text("<r><a\"");
    send_text("<r x y=z>");
    doc.push_back(8'h80);
    doc.push_back(8'hFF);
    doc.push_back(8'h7F);
    send_doc();

    cfg_write(xstb_pkg::CFG_ARENA_RECORDS, 1);
    send_text("<r><a/>hi</r>");
    send_text("<r a='1'>");
    cfg_write(xstb_pkg::CFG_ARENA_START, 0);
    send_text("<r/>");
    send_text("<r/>");
    cfg_write(xstb_pkg::CFG_ARENA_START, 65535);
    cfg_write(xstb_pkg::CFG_ARENA_RECORDS, 16777215);
    send_text("<r>");
    send_text("<r><s/></r>");

    sent = 0;
    docs_since_cfg = 0;
    held = 0;
    paused = 0;
    while (sent < RANDOM_ITEMS) begin
      if (docs_since_cfg >= 4 && sent < RANDOM_ITEMS - 60) begin
        docs_since_cfg = 0;
        cfg_write(xstb_pkg::CFG_ARENA_START, $urandom_range(0, 65535));
        cfg_write(xstb_pkg::CFG_ARENA_RECORDS, $urandom_range(0, 2) == 0 ?
                  $urandom_range(1, 6) : $urandom_range(1000, 16777215));
      end
      if (!held && sent > RANDOM_ITEMS / 3) begin
        held = 1;
        hold_asks++;
      end
      if (!paused && sent > 2 * RANDOM_ITEMS / 3) begin
        paused = 1;
        while (sb.pending.size() != 0) @(negedge clk);
      end
      if (sent > RANDOM_ITEMS - 40) calm = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 20))
          doc.push_back($urandom_range(0, 3) == 0 ? "<" : 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 2) == 0) add_str("<?xml v?>\n");
        add_elem(0);
        if ($urandom_range(0, 4) == 0) doc = doc[0:$urandom_range(0, doc.size() - 1)];
      end
      sent += doc.size();
      docs_since_cfg++;
      send_doc();
    end

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("run: %0d bytes in %0d documents, %0d results checked, %0d mismatches",
             sb.bytes_in, sb.docs, sb.results, sb.errors);
    $display("covered arena extremes, overflow, stack underflow, truncated documents, stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
